>>> rtl/core/jpcu_pkg.sv
// ----------------------------------------------------------------------------
// jpcu_pkg
// Shared types and constants for the numeric conversion pipeline.
// ----------------------------------------------------------------------------
package jpcu_pkg;

  // conversion opcodes
  typedef enum logic [3:0] {
    A_I2L = 4'd0,  A_I2F = 4'd1,  A_I2D = 4'd2,  A_L2I = 4'd3,
    A_L2F = 4'd4,  A_L2D = 4'd5,  A_F2I = 4'd6,  A_F2L = 4'd7,
    A_F2D = 4'd8,  A_D2I = 4'd9,  A_D2L = 4'd10, A_D2F = 4'd11,
    A_I2B = 4'd12, A_I2C = 4'd13, A_I2S = 4'd14
  } action_t;

  // how an item is finished
  typedef enum logic [1:0] {
    K_DIRECT = 2'd0,
    K_TOINT  = 2'd1,
    K_TOFP   = 2'd2
  } kind_t;

  localparam logic [1:0] WORDS_ONE = 2'd1;
  localparam logic [1:0] WORDS_TWO = 2'd2;

  // exponent given to infinities so that they saturate or overflow
  localparam logic signed [12:0] EXP_INF = 13'sd4095;

  // unpacked operand travelling down the pipeline
  typedef struct packed {
    kind_t              kind;
    logic               wide;     // long or double target
    logic               sign;
    logic [63:0]        mant;     // value = mant * 2^(expo - 63)
    logic signed [12:0] expo;
    logic [6:0]         lzc;
    logic               zero;
    logic [63:0]        direct;
    logic [1:0]         dwords;
  } pipe_t;

  // rounding or truncation prepared, final step pending
  typedef struct packed {
    kind_t       kind;
    logic        wide;
    logic        sign;
    logic        sat;
    logic        ovf;
    logic        inc;
    logic [63:0] mag;             // integer magnitude or packed fp field
    logic [63:0] direct;
    logic [1:0]  dwords;
  } rnd_t;

endpackage

>>> rtl/core/jvm_primitive_conversion_unit.sv
// Throughput: one item per cycle while the output is not stalled, every stage is a plain register stage.
// A stall at the output holds the whole pipeline in place; nothing is dropped.
// Reset clears the valid bits only; no clearing pass is needed.
// ----------------------------------------------------------------------------
// jvm_primitive_conversion_unit
// Five-stage pipeline for the fifteen numeric conversion opcodes.
// ----------------------------------------------------------------------------
module jvm_primitive_conversion_unit import jpcu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  action,
  input  logic [31:0] operand_low,
  input  logic [31:0] operand_high,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] result_low,
  output logic [31:0] result_high,
  output logic [1:0]  result_words
);

  logic        en;
  logic        v1;
  logic        v3;
  pipe_t       p1;
  pipe_t       p3;
  logic [63:0] res;

  // whole pipeline moves when the last stage is free
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  jpcu_unpack u_unpack (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .v_in         (in_valid),
    .action       (action),
    .operand_low  (operand_low),
    .operand_high (operand_high),
    .v_out        (v1),
    .q            (p1)
  );

  jpcu_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .v_in  (v1),
    .d     (p1),
    .v_out (v3),
    .q     (p3)
  );

  jpcu_round u_round (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .v_in  (v3),
    .d     (p3),
    .v_out (out_valid),
    .res   (res),
    .words (result_words)
  );

  // result words
  assign result_low  = res[31:0];
  assign result_high = res[63:32];

`ifndef SYNTH
  a_one_word_high_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_words == WORDS_ONE) |-> (result_high == 32'd0))
    else $error("single-word result with non-zero high word");

  a_words_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (result_words == WORDS_ONE) || (result_words == WORDS_TWO))
    else $error("illegal word count");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("pipeline stalled with empty output");
`endif

endmodule

>>> rtl/core/jpcu_unpack.sv
// ----------------------------------------------------------------------------
// jpcu_unpack
// First stage: decodes the opcode, unpacks the operand and settles NaNs.
// ----------------------------------------------------------------------------
module jpcu_unpack import jpcu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        v_in,
  input  logic [3:0]  action,
  input  logic [31:0] operand_low,
  input  logic [31:0] operand_high,
  output logic        v_out,
  output pipe_t       q
);

  pipe_t       d;
  logic [63:0] wide_op;
  logic [7:0]  fe;
  logic [22:0] ff;
  logic [10:0] de;
  logic [51:0] df;
  logic        f_nan;
  logic        d_nan;

  assign wide_op = {operand_high, operand_low};
  assign fe      = operand_low[30:23];
  assign ff      = operand_low[22:0];
  assign de      = operand_high[30:20];
  assign df      = wide_op[51:0];
  assign f_nan   = (fe == 8'hFF) && (ff != 23'd0);
  assign d_nan   = (de == 11'h7FF) && (df != 52'd0);

  // opcode decode
  always_comb begin
    d        = '0;
    d.kind   = K_DIRECT;
    d.dwords = WORDS_ONE;
    unique case (action_t'(action))
      A_I2L: begin
        d.direct = {{32{operand_low[31]}}, operand_low};
        d.dwords = WORDS_TWO;
      end
      A_I2F, A_I2D: begin
        d.kind = K_TOFP;
        d.wide = (action_t'(action) == A_I2D);
        d.sign = operand_low[31];
        d.mant = {32'd0, operand_low[31] ? (32'd0 - operand_low) : operand_low};
        d.expo = 13'sd63;
      end
      A_L2I: d.direct = {32'd0, operand_low};
      A_L2F, A_L2D: begin
        d.kind = K_TOFP;
        d.wide = (action_t'(action) == A_L2D);
        d.sign = operand_high[31];
        d.mant = operand_high[31] ? (64'd0 - wide_op) : wide_op;
        d.expo = 13'sd63;
      end
      A_F2I, A_F2L, A_F2D: begin
        d.wide = (action_t'(action) != A_F2I);
        d.kind = (action_t'(action) == A_F2D) ? K_TOFP : K_TOINT;
        d.sign = operand_low[31];
        if (d.wide) begin
          d.dwords = WORDS_TWO;
        end
        if (fe == 8'hFF) begin
          d.mant = {1'b1, 63'd0};
          d.expo = EXP_INF;
        end else begin
          d.mant = {(fe != 8'd0), ff, 40'd0};
          d.expo = (fe == 8'd0) ? -13'sd126 : ($signed({5'd0, fe}) - 13'sd127);
        end
        // quiet nan widening or zero for integers
        if (f_nan) begin
          d.kind = K_DIRECT;
          if (action_t'(action) == A_F2D) begin
            d.direct = {operand_low[31], 11'h7FF, 1'b1, ff[21:0], 29'd0};
          end else begin
            d.direct = '0;
          end
        end
      end
      A_D2I, A_D2L, A_D2F: begin
        d.wide = (action_t'(action) == A_D2L);
        d.kind = (action_t'(action) == A_D2F) ? K_TOFP : K_TOINT;
        d.sign = operand_high[31];
        if (d.wide) begin
          d.dwords = WORDS_TWO;
        end
        if (de == 11'h7FF) begin
          d.mant = {1'b1, 63'd0};
          d.expo = EXP_INF;
        end else begin
          d.mant = {(de != 11'd0), df, 11'd0};
          d.expo = (de == 11'd0) ? -13'sd1022 : ($signed({2'd0, de}) - 13'sd1023);
        end
        // quiet nan narrowing or zero for integers
        if (d_nan) begin
          d.kind = K_DIRECT;
          if (action_t'(action) == A_D2F) begin
            d.direct = {32'd0, operand_high[31], 8'hFF, 1'b1, df[50:29]};
          end else begin
            d.direct = '0;
          end
        end
      end
      A_I2B: d.direct = {32'd0, {24{operand_low[7]}}, operand_low[7:0]};
      A_I2C: d.direct = {48'd0, operand_low[15:0]};
      A_I2S: d.direct = {32'd0, {16{operand_low[15]}}, operand_low[15:0]};
      default: d.direct = '0;
    endcase
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
    if (en) begin
      q <= d;
    end
  end

endmodule

>>> rtl/core/jpcu_norm.sv
// ----------------------------------------------------------------------------
// jpcu_norm
// Second and third stages: leading-zero count, then normalising shift.
// ----------------------------------------------------------------------------
module jpcu_norm import jpcu_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  v_in,
  input  pipe_t d,
  output logic  v_out,
  output pipe_t q
);

  pipe_t      s2;
  pipe_t      s2_next;
  pipe_t      q_next;
  logic       v2;
  logic [6:0] cnt;
  logic [7:0] grp_nz;
  logic [2:0] grp_lz [8];

  // per-byte leading zeros, most significant byte is group 0
  always_comb begin
    for (int g = 0; g < 8; g++) begin
      grp_nz[g] = |d.mant[63 - 8*g -: 8];
      grp_lz[g] = 3'd0;
      for (int b = 0; b < 8; b++) begin
        if (d.mant[63 - 8*g - b] && (grp_lz[g] == 3'd0) &&
            !(|(d.mant[63 - 8*g -: 8] >> (8 - b)))) begin
          grp_lz[g] = 3'(b);
        end
      end
    end
  end

  // first non-empty byte
  always_comb begin
    cnt = 7'd64;
    for (int g = 7; g >= 0; g--) begin
      if (grp_nz[g]) begin
        cnt = {1'b0, 3'(g), grp_lz[g]};
      end
    end
  end

  // next contents of the count and shift stages
  always_comb begin
    s2_next      = d;
    s2_next.lzc  = cnt;
    s2_next.zero = (d.mant == 64'd0);
    q_next       = s2;
    q_next.mant  = s2.mant << s2.lzc;
    q_next.expo  = s2.expo - $signed({6'd0, s2.lzc});
  end

  // count and shift stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v2    <= 1'b0;
      v_out <= 1'b0;
    end else if (en) begin
      v2    <= v_in;
      v_out <= v2;
    end
    if (en) begin
      s2 <= s2_next;
      q  <= q_next;
    end
  end

endmodule

>>> rtl/core/jpcu_round.sv
// ----------------------------------------------------------------------------
// jpcu_round
// Fourth and fifth stages: truncation or rounding, then sign, carry and pack.
// ----------------------------------------------------------------------------
module jpcu_round import jpcu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        v_in,
  input  pipe_t       d,
  output logic        v_out,
  output logic [63:0] res,
  output logic [1:0]  words
);

  rnd_t               r4;
  rnd_t               n4;
  logic               v4;
  logic signed [12:0] emin;
  logic signed [12:0] emax;
  logic signed [12:0] bias;
  logic signed [12:0] diff;
  logic signed [12:0] be;
  logic [13:0]        shx;
  logic [6:0]         base;
  logic [6:0]         shamt;
  logic [63:0]        kept;
  logic [63:0]        gbits;
  logic [63:0]        smask;
  logic               den;
  logic               sticky;
  logic [62:0]        sum;
  logic [63:0]        ival;
  logic [63:0]        res_next;
  logic [1:0]         words_next;

  // fp rounding set-up
  always_comb begin
    emin  = d.wide ? -13'sd1022 : -13'sd126;
    emax  = d.wide ? 13'sd1023 : 13'sd127;
    bias  = d.wide ? 13'sd1023 : 13'sd127;
    base  = d.wide ? 7'd11 : 7'd40;
    den   = d.expo < emin;
    diff  = emin - d.expo;
    shx   = {7'd0, base} + 14'(unsigned'(diff));
    shamt = den ? ((shx > 14'd65) ? 7'd65 : shx[6:0]) : base;
    kept  = d.mant >> shamt;
    gbits = d.mant >> (shamt - 7'd1);
    smask = (64'd1 << (shamt - 7'd1)) - 64'd1;
    sticky = |(d.mant & smask);
    be    = den ? 13'sd0 : (d.expo + bias);
  end

  // stage four contents
  always_comb begin
    n4        = '0;
    n4.kind   = d.kind;
    n4.wide   = d.wide;
    n4.sign   = d.sign;
    n4.direct = d.direct;
    n4.dwords = d.dwords;
    unique case (d.kind)
      K_TOINT: begin
        n4.sat = !d.zero && (d.expo >= (d.wide ? 13'sd63 : 13'sd31));
        if (!d.zero && (d.expo >= 13'sd0) && !n4.sat) begin
          n4.mag = d.mant >> (7'd63 - d.expo[6:0]);
        end
      end
      K_TOFP: begin
        if (!d.zero) begin
          n4.ovf = !den && (d.expo > emax);
          n4.inc = gbits[0] && (sticky || kept[0]);
          n4.mag = d.wide ? {1'b0, be[10:0], kept[51:0]}
                          : {33'd0, be[7:0], kept[22:0]};
        end
      end
      default: n4.mag = '0;
    endcase
  end

  // final pack
  always_comb begin
    sum        = r4.mag[62:0] + {62'd0, r4.inc};
    ival       = r4.sign ? (64'd0 - r4.mag) : r4.mag;
    res_next   = r4.direct;
    words_next = r4.dwords;
    unique case (r4.kind)
      K_TOINT: begin
        if (r4.wide) begin
          res_next   = r4.sat ? (r4.sign ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : ival;
          words_next = WORDS_TWO;
        end else begin
          res_next   = {32'd0, r4.sat ? (r4.sign ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}})
                                      : ival[31:0]};
          words_next = WORDS_ONE;
        end
      end
      K_TOFP: begin
        if (r4.wide) begin
          res_next   = {r4.sign, r4.ovf ? {11'h7FF, 52'd0} : sum};
          words_next = WORDS_TWO;
        end else begin
          res_next   = {32'd0, r4.sign, r4.ovf ? {8'hFF, 23'd0} : sum[30:0]};
          words_next = WORDS_ONE;
        end
      end
      default: res_next = r4.direct;
    endcase
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v4    <= 1'b0;
      v_out <= 1'b0;
    end else if (en) begin
      v4    <= v_in;
      v_out <= v4;
    end
    if (en) begin
      r4    <= n4;
      res   <= res_next;
      words <= words_next;
    end
  end

endmodule
